[sv/abrb_pkg.sv]
// Shared types and constants for the audio block ring buffer.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package abrb_pkg;

  localparam int RING_BYTES_DEF = 4096;

  localparam int BLK_W        = 13;
  localparam int RB_W         = 7;
  localparam int DLY_W        = 7;
  localparam int PROD_W       = BLK_W + RB_W;
  localparam int TH_W         = DLY_W + BLK_W;
  localparam int DATA_W       = 8;
  localparam int STATUS_W     = 2;
  localparam int FILL_LEVEL_W = 13;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 4;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [BLK_W-1:0] RST_BLOCK_BYTES  = 13'd512;
  localparam logic [RB_W-1:0]  RST_RING_BLOCKS  = 7'd8;
  localparam logic [DLY_W-1:0] RST_DELAY_BLOCKS = 7'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_BLOCK_BYTES  = 2'd0;
  localparam logic [1:0] REG_RING_BLOCKS  = 2'd1;
  localparam logic [1:0] REG_DELAY_BLOCKS = 2'd2;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COMMIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP   = 2'd2;

  typedef enum logic [1:0] {
    KIND_FEED_START,
    KIND_FEED_BYTE,
    KIND_READ_START,
    KIND_READ_BYTE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              last;
    logic [DATA_W-1:0] data;
  } item_t;

  // effective (non-zero) block size, need-more threshold and write strobe
  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [TH_W-1:0]  thresh;
    logic             wr;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_LOAD,
    BK_DIV,
    BK_FIX
  } bk_state_t;

endpackage

`default_nettype wire

[sv/abrb_if.sv]
// Valid/ready channel interfaces for items in and results out.
// Depends on abrb_pkg for field widths.
`default_nettype none

interface abrb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [abrb_pkg::DATA_W-1:0] data_byte;
  logic                       first_flag;
  logic                       last_of_request;

  modport source (output valid, opcode, data_byte, first_flag, last_of_request,
                  input ready);
  modport sink (input valid, opcode, data_byte, first_flag, last_of_request,
                output ready);
endinterface

interface abrb_out_if;
  logic                             valid;
  logic                             ready;
  logic [abrb_pkg::DATA_W-1:0]       out_byte;
  logic                             padded;
  logic [abrb_pkg::STATUS_W-1:0]     block_status;
  logic                             need_more;
  logic [abrb_pkg::FILL_LEVEL_W-1:0] fill_level;

  modport source (output valid, out_byte, padded, block_status, need_more, fill_level,
                  input ready);
  modport sink (input valid, out_byte, padded, block_status, need_more, fill_level,
                output ready);
endinterface

`default_nettype wire

[sv/audio_block_ring_buffer_core.sv]
// Results: an item taken by the back end passes the pending result stage, then the output
// register. Sustained rate is one item per cycle, set by the single back-end execute stage and
// one store access per item, while the output is not stalled. After every register write the
// back end takes no items while it reduces the pointers modulo the new ring size;
// input stalls once the 4-entry queue fills.
// Reset (synchronous, rst_n low) clears pointers, fill, counters and handshakes and loads the
// register defaults; the ring store is not cleared.
`default_nettype none

module audio_block_ring_buffer_core #(
  parameter int RING_BYTES = abrb_pkg::RING_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  abrb_in_if.sink                          in_ch,
  abrb_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [abrb_pkg::APB_AW-1:0] paddr,
  input  wire logic [abrb_pkg::APB_DW-1:0] pwdata,
  output logic      [abrb_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);

  localparam int RW = $clog2(RING_BYTES + 1);

  abrb_pkg::cfg_t  cfg;
  logic [RW-1:0]   ring;
  logic            push_valid;
  logic            push_ready;
  abrb_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  abrb_pkg::item_t pop_item;

  abrb_cfg #(
    .RING_BYTES (RING_BYTES)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .ring    (ring)
  );

  abrb_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  abrb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  abrb_back #(
    .RING_BYTES (RING_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .cfg       (cfg),
    .ring      (ring),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[sv/abrb_cfg.sv]
// APB register file: block_bytes, ring_blocks, delay_blocks, plus the
// registered ring size and need-more threshold. Depends on abrb_pkg.
`default_nettype none

module abrb_cfg #(
  parameter int RING_BYTES = abrb_pkg::RING_BYTES_DEF,
  localparam int RW = $clog2(RING_BYTES + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [abrb_pkg::APB_AW-1:0]   paddr,
  input  wire logic [abrb_pkg::APB_DW-1:0]   pwdata,
  output logic      [abrb_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output abrb_pkg::cfg_t                     cfg,
  output logic      [RW-1:0]                 ring
);

  localparam int PROD_W = abrb_pkg::PROD_W;
  localparam int TH_W   = abrb_pkg::TH_W;
  localparam int BLK_W  = abrb_pkg::BLK_W;
  localparam int RST_PROD = int'(abrb_pkg::RST_BLOCK_BYTES) * int'(abrb_pkg::RST_RING_BLOCKS);
  localparam int RST_RING = (RST_PROD > RING_BYTES) ? RING_BYTES : RST_PROD;
  localparam int RST_TH   = int'(abrb_pkg::RST_BLOCK_BYTES) * int'(abrb_pkg::RST_DELAY_BLOCKS);

  logic [BLK_W-1:0]           blk_r;
  logic [abrb_pkg::RB_W-1:0]  rb_r;
  logic [abrb_pkg::DLY_W-1:0] dly_r;
  logic [BLK_W-1:0]           blk_eff_r;
  logic [RW-1:0]              ring_r;
  logic [TH_W-1:0]            thresh_r;

  logic                       wr;
  logic [1:0]                 idx;
  logic [BLK_W-1:0]           blk_eff;
  logic [abrb_pkg::RB_W-1:0]  rb_eff;
  logic [PROD_W-1:0]          prod;
  logic [RW-1:0]              ring_nxt;
  logic [TH_W-1:0]            thresh_nxt;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r <= abrb_pkg::RST_BLOCK_BYTES;
      rb_r  <= abrb_pkg::RST_RING_BLOCKS;
      dly_r <= abrb_pkg::RST_DELAY_BLOCKS;
    end else if (wr) begin
      unique case (idx)
        abrb_pkg::REG_BLOCK_BYTES:  blk_r <= pwdata[BLK_W-1:0];
        abrb_pkg::REG_RING_BLOCKS:  rb_r  <= pwdata[abrb_pkg::RB_W-1:0];
        abrb_pkg::REG_DELAY_BLOCKS: dly_r <= pwdata[abrb_pkg::DLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      abrb_pkg::REG_BLOCK_BYTES:  prdata = abrb_pkg::APB_DW'(blk_r);
      abrb_pkg::REG_RING_BLOCKS:  prdata = abrb_pkg::APB_DW'(rb_r);
      abrb_pkg::REG_DELAY_BLOCKS: prdata = abrb_pkg::APB_DW'(dly_r);
      default:                    prdata = '0;
    endcase
  end

  // zero counts as one block / one byte
  assign blk_eff    = (blk_r == '0) ? BLK_W'(1) : blk_r;
  assign rb_eff     = (rb_r == '0) ? abrb_pkg::RB_W'(1) : rb_r;
  assign prod       = PROD_W'(blk_eff) * PROD_W'(rb_eff);
  assign ring_nxt   = (prod > PROD_W'(RING_BYTES)) ? RW'(RING_BYTES) : RW'(prod);
  assign thresh_nxt = TH_W'(dly_r) * TH_W'(blk_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_eff_r <= abrb_pkg::RST_BLOCK_BYTES;
      ring_r    <= RW'(RST_RING);
      thresh_r  <= TH_W'(RST_TH);
    end else begin
      blk_eff_r <= blk_eff;
      ring_r    <= ring_nxt;
      thresh_r  <= thresh_nxt;
    end
  end

  assign cfg.blk    = blk_eff_r;
  assign cfg.thresh = thresh_r;
  assign cfg.wr     = wr;
  assign ring       = ring_r;

endmodule

`default_nettype wire

[sv/abrb_front.sv]
// Front end: takes input transactions and classifies them into item kinds.
// Depends on abrb_pkg and abrb_in_if.
`default_nettype none

module abrb_front (
  abrb_in_if.sink              in_ch,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output abrb_pkg::item_t      push_item
);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_item.last = 1'b0;
    push_item.data = '0;
    if (in_ch.opcode == abrb_pkg::OP_FEED) begin
      // drop last flag on feeds
      push_item.kind = in_ch.first_flag ? abrb_pkg::KIND_FEED_START
                                        : abrb_pkg::KIND_FEED_BYTE;
      push_item.data = in_ch.data_byte;
    end else begin
      push_item.kind = in_ch.first_flag ? abrb_pkg::KIND_READ_START
                                        : abrb_pkg::KIND_READ_BYTE;
      push_item.last = in_ch.last_of_request;
    end
  end

endmodule

`default_nettype wire

[sv/abrb_queue.sv]
// Short item queue between the front and the back end.
// Depends on abrb_pkg.
`default_nettype none

module abrb_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire abrb_pkg::item_t  push_item,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output abrb_pkg::item_t       pop_item
);

  localparam int DEPTH = abrb_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  abrb_pkg::item_t slot_r [DEPTH];
  logic [AW-1:0]   wp_r;
  logic [AW-1:0]   rp_r;
  logic [AW:0]     cnt_r;
  logic            push;
  logic            pop;

  assign push_ready = cnt_r != (AW + 1)'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_item   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (pop)  rp_r <= rp_r + AW'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + (AW + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (AW + 1)'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW + 1)'(DEPTH))
    else $error("queue count beyond depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + (AW + 1)'(1))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

[sv/abrb_back.sv]
// Back end: carries out feed and read items against the ring store, keeps
// pointers and fill, reduces pointers modulo the ring after register writes,
// and holds the result register. Depends on abrb_pkg and abrb_out_if.
`default_nettype none

module abrb_back #(
  parameter int RING_BYTES = abrb_pkg::RING_BYTES_DEF,
  localparam int PW     = $clog2(RING_BYTES),
  localparam int RW     = $clog2(RING_BYTES + 1),
  localparam int FILL_W = $clog2(RING_BYTES + 2 ** abrb_pkg::BLK_W)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire abrb_pkg::item_t  pop_item,
  input  wire abrb_pkg::cfg_t   cfg,
  input  wire logic [RW-1:0]    ring,
  abrb_out_if.source            out_ch
);

  localparam int BLK_W = abrb_pkg::BLK_W;
  localparam int TH_W  = abrb_pkg::TH_W;
  localparam int CW    = (FILL_W > TH_W) ? FILL_W : TH_W;
  localparam int SW    = $clog2(FILL_W);
  localparam int RW1   = RW + 1;
  localparam int DW    = abrb_pkg::DATA_W;
  localparam int FLW   = abrb_pkg::FILL_LEVEL_W;

  localparam logic [1:0] NRM_COMMIT  = 2'd0;
  localparam logic [1:0] NRM_WRITE   = 2'd1;
  localparam logic [1:0] NRM_RPOS    = 2'd2;
  localparam logic [1:0] NRM_RSERVED = 2'd3;

  // ring store
  logic [DW-1:0] store_mem [RING_BYTES];
  logic [DW-1:0] rd_q_r;

  // control state
  abrb_pkg::bk_state_t state_r, state_nxt;
  logic                pend_r, pend_nxt;
  logic [1:0]          nidx_r, nidx_nxt;

  // pointers: as last written, and reduced modulo the current ring
  logic [PW-1:0]     commit_raw_r, write_raw_r, rpos_raw_r;
  logic [PW-1:0]     commit_n_r, write_n_r, rpos_n_r, rd_addr_r, rsm_r;
  logic [FILL_W-1:0] fill_r, avail_r, served_r;
  logic [BLK_W-1:0]  bcount_r;
  logic              baccept_r;

  // modulo unit
  logic [SW-1:0]     step_r;
  logic [FILL_W-1:0] shift_r;
  logic [RW-1:0]     rem_r;
  logic [RW1-1:0]    div_try;
  logic              div_ge;
  logic [RW-1:0]     rem_step;
  logic              div_last;
  logic [RW1-1:0]    fix_sum;
  logic [RW1-1:0]    fix_red;

  // pending result stage and output register
  logic              p_vld_r, p_srv_r, p_pad_r, p_need_r;
  logic [abrb_pkg::STATUS_W-1:0] p_status_r;
  logic [FLW-1:0]    p_fill_r;
  logic              p_move;
  logic              out_vld_r, out_pad_r, out_need_r;
  logic [DW-1:0]     out_byte_r;
  logic [abrb_pkg::STATUS_W-1:0] out_status_r;
  logic [FLW-1:0]    out_fill_r;

  // execution
  logic              pop;
  logic              start_c, bacc_c, srv_hit_c;
  logic              commit_we_c, wpos_we_c, rpos_we_c;
  logic [PW-1:0]     wpos_c, ra_c, commit_c, rpos_c;
  logic [BLK_W-1:0]  bcnt_c;
  logic [FILL_W-1:0] freesp_c, fill_c, avl_c, srv_c;
  logic              mem_we, mem_re;
  logic [PW-1:0]     mem_wa, mem_ra;
  logic [abrb_pkg::STATUS_W-1:0] status_c;
  logic              pad_c, need_c;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] a,
                                             input logic [RW-1:0] sz);
    logic [RW-1:0] s;
    s = RW'(a) + RW'(1);
    return (s >= sz) ? '0 : PW'(s);
  endfunction

  // ---------------------------------------------------------------- FSM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= abrb_pkg::BK_RUN;
      pend_r  <= 1'b0;
      nidx_r  <= NRM_COMMIT;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      nidx_r  <= nidx_nxt;
    end
  end

  assign div_last = step_r == SW'(FILL_W - 1);
  assign p_move   = p_vld_r & (~out_vld_r | out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    nidx_nxt  = nidx_r;
    pend_nxt  = pend_r;
    pop_ready = 1'b0;
    unique case (state_r)
      abrb_pkg::BK_RUN: begin
        if (pend_r) begin
          state_nxt = abrb_pkg::BK_LOAD;
          nidx_nxt  = NRM_COMMIT;
          pend_nxt  = 1'b0;
        end else begin
          pop_ready = ~p_vld_r | p_move;
        end
      end
      abrb_pkg::BK_LOAD: state_nxt = abrb_pkg::BK_DIV;
      abrb_pkg::BK_DIV: begin
        if (div_last) begin
          if (nidx_r == NRM_RSERVED) begin
            state_nxt = abrb_pkg::BK_FIX;
          end else begin
            state_nxt = abrb_pkg::BK_LOAD;
            nidx_nxt  = nidx_r + 2'd1;
          end
        end
      end
      abrb_pkg::BK_FIX: begin
        // restart if the registers changed during the pass
        if (pend_r) begin
          state_nxt = abrb_pkg::BK_LOAD;
          nidx_nxt  = NRM_COMMIT;
          pend_nxt  = 1'b0;
        end else begin
          state_nxt = abrb_pkg::BK_RUN;
        end
      end
      default: state_nxt = abrb_pkg::BK_RUN;
    endcase
    if (cfg.wr) pend_nxt = 1'b1;
  end

  // ---------------------------------------------------------------- execution
  assign pop = pop_valid & pop_ready;

  always_comb begin
    start_c     = 1'b0;
    bacc_c      = baccept_r;
    wpos_c      = write_n_r;
    bcnt_c      = bcount_r;
    commit_c    = commit_n_r;
    rpos_c      = rpos_n_r;
    ra_c        = rd_addr_r;
    fill_c      = fill_r;
    avl_c       = avail_r;
    srv_c       = served_r;
    srv_hit_c   = 1'b0;
    commit_we_c = 1'b0;
    wpos_we_c   = 1'b0;
    rpos_we_c   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wa      = write_n_r;
    mem_ra      = rd_addr_r;
    status_c    = abrb_pkg::ST_NONE;
    pad_c       = 1'b0;
    freesp_c    = (FILL_W'(ring) > fill_r) ? FILL_W'(ring) - fill_r : '0;
    if (pop) begin
      unique case (pop_item.kind)
        abrb_pkg::KIND_FEED_START, abrb_pkg::KIND_FEED_BYTE: begin
          start_c = pop_item.kind == abrb_pkg::KIND_FEED_START;
          if (start_c) begin
            bacc_c    = freesp_c >= FILL_W'(cfg.blk);
            wpos_c    = commit_n_r;
            wpos_we_c = 1'b1;
            bcnt_c    = '0;
          end
          // stray bytes outside a block do nothing
          if (start_c || bcount_r != '0) begin
            if (bacc_c) begin
              mem_we    = 1'b1;
              mem_wa    = wpos_c;
              wpos_c    = wrap_inc(wpos_c, ring);
              wpos_we_c = 1'b1;
            end
            bcnt_c = bcnt_c + BLK_W'(1);
            if (bcnt_c >= cfg.blk) begin
              if (bacc_c) begin
                commit_c    = wpos_c;
                commit_we_c = 1'b1;
                fill_c      = fill_r + FILL_W'(cfg.blk);
                status_c    = abrb_pkg::ST_COMMIT;
              end else begin
                status_c = abrb_pkg::ST_DROP;
              end
              bcnt_c = '0;
            end
          end
        end
        abrb_pkg::KIND_READ_START, abrb_pkg::KIND_READ_BYTE: begin
          start_c = pop_item.kind == abrb_pkg::KIND_READ_START;
          if (start_c) begin
            avl_c = fill_r;
            srv_c = '0;
            ra_c  = rpos_n_r;
          end
          if (srv_c < avl_c) begin
            mem_re    = 1'b1;
            mem_ra    = ra_c;
            ra_c      = wrap_inc(ra_c, ring);
            srv_c     = srv_c + FILL_W'(1);
            srv_hit_c = 1'b1;
          end else begin
            pad_c = 1'b1;
          end
          if (pop_item.last) begin
            rpos_c    = ra_c;
            rpos_we_c = 1'b1;
            fill_c    = (fill_r > srv_c) ? fill_r - srv_c : '0;
            avl_c     = '0;
            srv_c     = '0;
          end
        end
        default: ;
      endcase
    end
    need_c = CW'(fill_c) < CW'(cfg.thresh);
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_wa] <= pop_item.data;
    if (mem_re) rd_q_r <= store_mem[mem_ra];
  end

  // ---------------------------------------------------------------- modulo unit
  assign div_try  = {rem_r, shift_r[FILL_W-1]};
  assign div_ge   = div_try >= RW1'(ring);
  assign rem_step = div_ge ? RW'(div_try - RW1'(ring)) : RW'(div_try);
  assign fix_sum  = RW1'(rpos_n_r) + RW1'(rsm_r);
  assign fix_red  = (fix_sum >= RW1'(ring)) ? fix_sum - RW1'(ring) : fix_sum;

  always_ff @(posedge clk) begin
    if (state_r == abrb_pkg::BK_LOAD) begin
      rem_r  <= '0;
      step_r <= '0;
      unique case (nidx_r)
        NRM_COMMIT:  shift_r <= FILL_W'(commit_raw_r);
        NRM_WRITE:   shift_r <= FILL_W'(write_raw_r);
        NRM_RPOS:    shift_r <= FILL_W'(rpos_raw_r);
        NRM_RSERVED: shift_r <= served_r;
        default:     shift_r <= '0;
      endcase
    end else if (state_r == abrb_pkg::BK_DIV) begin
      rem_r   <= rem_step;
      shift_r <= shift_r << 1;
      step_r  <= step_r + SW'(1);
    end
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      commit_raw_r <= '0;
      write_raw_r  <= '0;
      rpos_raw_r   <= '0;
      commit_n_r   <= '0;
      write_n_r    <= '0;
      rpos_n_r     <= '0;
      rd_addr_r    <= '0;
      rsm_r        <= '0;
      fill_r       <= '0;
      avail_r      <= '0;
      served_r     <= '0;
      bcount_r     <= '0;
      baccept_r    <= 1'b0;
    end else if (pop) begin
      // raw copies change only when the item writes that pointer
      if (commit_we_c) commit_raw_r <= commit_c;
      if (wpos_we_c)   write_raw_r  <= wpos_c;
      if (rpos_we_c)   rpos_raw_r   <= rpos_c;
      commit_n_r   <= commit_c;
      write_n_r    <= wpos_c;
      rpos_n_r     <= rpos_c;
      rd_addr_r    <= ra_c;
      fill_r       <= fill_c;
      avail_r      <= avl_c;
      served_r     <= srv_c;
      bcount_r     <= bcnt_c;
      baccept_r    <= bacc_c;
    end else if (state_r == abrb_pkg::BK_DIV && div_last) begin
      unique case (nidx_r)
        NRM_COMMIT:  commit_n_r <= rem_step[PW-1:0];
        NRM_WRITE:   write_n_r  <= rem_step[PW-1:0];
        NRM_RPOS:    rpos_n_r   <= rem_step[PW-1:0];
        NRM_RSERVED: rsm_r      <= rem_step[PW-1:0];
        default: ;
      endcase
    end else if (state_r == abrb_pkg::BK_FIX) begin
      rd_addr_r <= fix_red[PW-1:0];
    end
  end

  // ---------------------------------------------------------------- results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (pop) begin
      p_vld_r <= 1'b1;
    end else if (p_move) begin
      p_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_srv_r    <= srv_hit_c;
      p_pad_r    <= pad_c;
      p_status_r <= status_c;
      p_need_r   <= need_c;
      p_fill_r   <= fill_c[FLW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (p_move) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      out_byte_r   <= p_srv_r ? rd_q_r : '0;
      out_pad_r    <= p_pad_r;
      out_status_r <= p_status_r;
      out_need_r   <= p_need_r;
      out_fill_r   <= p_fill_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.padded       = out_pad_r;
  assign out_ch.block_status = out_status_r;
  assign out_ch.need_more    = out_need_r;
  assign out_ch.fill_level   = out_fill_r;

  // ---------------------------------------------------------------- checks
  a_ptrs_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == abrb_pkg::BK_RUN && !pend_r) |->
      (write_n_r < ring && commit_n_r < ring && rpos_n_r < ring && rd_addr_r < ring))
    else $error("pointer not reduced modulo ring while taking items");

  a_served_le_avail: assert property (@(posedge clk) disable iff (!rst_n)
    served_r <= avail_r)
    else $error("read request served past latched count");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && out_vld_r && !out_ch.ready) |=> (p_vld_r && $stable(rd_q_r)))
    else $error("pending result or store data lost under stall");

  a_norm_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pend_r) |=> state_r != abrb_pkg::BK_RUN)
    else $error("register write did not start a reduction pass");

endmodule

`default_nettype wire

[tb/tb_audio_block_ring_buffer_core.sv]
// Self-checking bench for audio_block_ring_buffer_core: bursty producer/playback traffic
// checked against a behavioural ring model, across several APB register settings.
// Depends on abrb_pkg and the abrb_in_if / abrb_out_if channel interfaces.
module tb_audio_block_ring_buffer_core;
  import abrb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic              op;
    logic [DATA_W-1:0] data;
    logic              first;
    logic              last;
  } ring_op_t;

  typedef struct {
    logic [DATA_W-1:0]       data_out;
    logic                    pad;
    logic [STATUS_W-1:0]     status;
    logic                    more;
    logic [FILL_LEVEL_W-1:0] fill;
  } ring_res_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  abrb_in_if  in_ch ();
  abrb_out_if out_ch ();

  audio_block_ring_buffer_core #(
    .RING_BYTES(RING_BYTES_DEF)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // behavioural copy of the ring, registers at their reset values
  logic [DATA_W-1:0] ring_mem [RING_BYTES_DEF];
  int unsigned cfg_block = RST_BLOCK_BYTES;
  int unsigned cfg_rings = RST_RING_BLOCKS;
  int unsigned cfg_delay = RST_DELAY_BLOCKS;
  int unsigned m_rd = 0, m_commit = 0, m_wr = 0, m_fill = 0;
  int unsigned m_accept = 0, m_count = 0, m_avail = 0, m_served = 0;

  ring_op_t  queued_ops [$];
  ring_res_t results_due [$];
  ring_op_t  drive_op;
  ring_res_t due;
  logic      in_taken;
  int        fail_count = 0;
  int        result_count = 0;
  int        cycle_count = 0;
  int        burst_left = 0, gap_left = 0;
  int        stall_mode = 0, stall_left = 0, stall_phase = 0;

  function automatic int unsigned eff_block();
    return (cfg_block == 0) ? 1 : cfg_block;
  endfunction

  function automatic int unsigned ring_span();
    int unsigned rb, p;
    rb = (cfg_rings == 0) ? 1 : cfg_rings;
    p  = eff_block() * rb;
    return (p > RING_BYTES_DEF) ? RING_BYTES_DEF : p;
  endfunction

  function automatic ring_res_t ring_step(ring_op_t op);
    int unsigned blk, ring, freesp, a;
    ring_res_t r;
    blk        = eff_block();
    ring       = ring_span();
    r.data_out = '0;
    r.pad      = 1'b0;
    r.status   = ST_NONE;
    if (op.op == OP_FEED) begin
      if (op.first) begin
        // admit the whole block or none of it
        freesp   = (ring > m_fill) ? ring - m_fill : 0;
        m_accept = (freesp >= blk);
        m_wr     = m_commit % ring;
        m_count  = 0;
      end
      if (op.first || m_count > 0) begin
        if (m_accept != 0) begin
          a           = m_wr % ring;
          ring_mem[a] = op.data;
          m_wr        = (a + 1 >= ring) ? 0 : a + 1;
        end
        m_count++;
        if (m_count >= blk) begin
          if (m_accept != 0) begin
            m_commit = m_wr;
            m_fill  += blk;
            r.status = ST_COMMIT;
          end else begin
            r.status = ST_DROP;
          end
          m_count = 0;
        end
      end
    end else begin
      if (op.first) begin
        m_avail  = m_fill;
        m_served = 0;
      end
      if (m_served < m_avail) begin
        a          = (m_rd % ring + m_served % ring) % ring;
        r.data_out = ring_mem[a];
        m_served++;
      end else begin
        r.pad = 1'b1;
      end
      if (op.last) begin
        m_rd     = (m_rd % ring + m_served % ring) % ring;
        m_fill   = (m_fill > m_served) ? m_fill - m_served : 0;
        m_avail  = 0;
        m_served = 0;
      end
    end
    r.more = (m_fill < cfg_delay * blk);
    r.fill = m_fill[FILL_LEVEL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    $display("[%0t] result %0d: %s got %0d, expected %0d", $time, result_count, what, got,
             want);
  endtask

  function automatic void push_op(logic op, logic [DATA_W-1:0] data, logic first,
                                  logic last);
    queued_ops.push_back(ring_op_t'{op, data, first, last});
  endfunction

  // build a feed run and a read run, then interleave them at random
  function automatic int queue_pair(int unsigned flen, bit ffirst, int unsigned rlen,
                                    bit rfirst, bit rlast);
    ring_op_t feeds [$];
    ring_op_t reads [$];
    ring_op_t op;
    for (int unsigned i = 0; i < flen; i++) begin
      op.op    = OP_FEED;
      op.data  = $urandom;
      op.first = (i == 0) && ffirst;
      op.last  = $urandom_range(1);
      feeds.push_back(op);
    end
    for (int unsigned i = 0; i < rlen; i++) begin
      op.op    = OP_READ;
      op.data  = $urandom;
      op.first = (i == 0) && rfirst;
      op.last  = (i == rlen - 1) && rlast;
      reads.push_back(op);
    end
    while (feeds.size() != 0 || reads.size() != 0) begin
      if (reads.size() == 0 || (feeds.size() != 0 && $urandom_range(1) == 1))
        queued_ops.push_back(feeds.pop_front());
      else
        queued_ops.push_back(reads.pop_front());
    end
    return flen + rlen;
  endfunction

  task automatic wait_quiet();
    do @(posedge clk);
    while (queued_ops.size() != 0 || in_ch.valid || results_due.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    case (idx)
      REG_BLOCK_BYTES:  cfg_block = value & ((1 << BLK_W) - 1);
      REG_RING_BLOCKS:  cfg_rings = value & ((1 << RB_W) - 1);
      REG_DELAY_BLOCKS: cfg_delay = value & ((1 << DLY_W) - 1);
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(int unsigned blk, int unsigned rings, int unsigned delay);
    write_reg(REG_BLOCK_BYTES, blk);
    write_reg(REG_RING_BLOCKS, rings);
    write_reg(REG_DELAY_BLOCKS, delay);
  endtask

  // finish any open block, then read the ring empty so the pointers meet
  task automatic close_phase();
    wait_quiet();
    if (m_count > 0) begin
      void'(queue_pair(eff_block() - m_count, 0, 0, 1, 1));
      wait_quiet();
    end
    void'(queue_pair(0, 1, (m_fill > 0) ? m_fill : 1, 1, 1));
    wait_quiet();
  endtask

  task automatic run_phase(int unsigned blk_reg, int unsigned rings, int unsigned delay,
                           int unsigned n_items);
    int unsigned pushed, blk, pick, rl, rmax;
    set_config(blk_reg, rings, delay);
    pushed = 0;
    blk    = eff_block();
    rmax   = (3 * blk + 2 > 48) ? 48 : 3 * blk + 2;
    while (pushed < n_items) begin
      pick = $urandom_range(99);
      rl   = $urandom_range(rmax, 1);
      if (pick < 45)
        pushed += queue_pair(blk, 1, (pick < 20) ? rl : 0, 1, 1);
      else if (pick < 72)
        pushed += queue_pair(0, 1, rl, 1, 1);
      else if (pick < 80)
        pushed += queue_pair($urandom_range(blk, 1), 1, 0, 1, 1);
      else if (pick < 87)
        pushed += queue_pair(0, 1, rl, 1, 0);
      else if (pick < 93)
        pushed += queue_pair(1, 0, 0, 1, 1);
      else
        pushed += queue_pair(0, 1, 1, 0, $urandom_range(1));
    end
    close_phase();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // check each result transaction, then predict for each accepted item
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result, fill_level", out_ch.fill_level, 'x);
        end else begin
          due = results_due.pop_front();
          if (out_ch.out_byte !== due.data_out)
            report_mismatch("out_byte", out_ch.out_byte, due.data_out);
          if (out_ch.padded !== due.pad)
            report_mismatch("padded", out_ch.padded, due.pad);
          if (out_ch.block_status !== due.status)
            report_mismatch("block_status", out_ch.block_status, due.status);
          if (out_ch.need_more !== due.more)
            report_mismatch("need_more", out_ch.need_more, due.more);
          if (out_ch.fill_level !== due.fill)
            report_mismatch("fill_level", out_ch.fill_level, due.fill);
        end
        result_count++;
      end
      if (in_ch.valid && in_ch.ready)
        results_due.push_back(ring_step(ring_op_t'{in_ch.opcode, in_ch.data_byte,
                                                   in_ch.first_flag, in_ch.last_of_request}));
      in_taken <= in_ch.valid && in_ch.ready;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // producer: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (queued_ops.size() != 0) begin
        drive_op = queued_ops.pop_front();
        in_ch.opcode          <= drive_op.op;
        in_ch.data_byte       <= drive_op.data;
        in_ch.first_flag      <= drive_op.first;
        in_ch.last_of_request <= drive_op.last;
        in_ch.valid           <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(24, 1);
          gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 1);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // playback side: stall pattern switches at random among four modes
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3);
      stall_left = $urandom_range(128, 32);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= $urandom_range(1);
      2:       out_ch.ready <= (stall_phase % 4) != 0;
      default: out_ch.ready <= (stall_phase % 8) == 0;
    endcase
  end

  initial begin
    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_ch.valid           = 1'b0;
    in_ch.opcode          = OP_FEED;
    in_ch.data_byte       = '0;
    in_ch.first_flag      = 1'b0;
    in_ch.last_of_request = 1'b0;
    out_ch.ready          = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: two-byte blocks in a four-byte ring
    set_config(2, 2, 1);
    push_op(OP_FEED, 8'hFF, 1'b0, 1'b1);  // stray feed byte, last flag ignored
    push_op(OP_READ, 8'h00, 1'b0, 1'b0);  // stray read gives padded silence
    push_op(OP_READ, 8'hFF, 1'b1, 1'b1);  // empty request, first and last together
    push_op(OP_FEED, 8'h00, 1'b1, 1'b0);
    push_op(OP_FEED, 8'hFF, 1'b0, 1'b1);
    push_op(OP_FEED, 8'hA5, 1'b1, 1'b0);
    push_op(OP_FEED, 8'h5A, 1'b0, 1'b0);  // ring now full
    push_op(OP_FEED, 8'h11, 1'b1, 1'b0);
    push_op(OP_FEED, 8'h22, 1'b0, 1'b0);  // no room: block dropped
    push_op(OP_READ, 8'hFF, 1'b1, 1'b0);
    push_op(OP_READ, 8'h00, 1'b0, 1'b0);
    push_op(OP_READ, 8'h55, 1'b0, 1'b0);
    push_op(OP_READ, 8'hAA, 1'b0, 1'b0);
    push_op(OP_READ, 8'h0F, 1'b0, 1'b1);  // runs past the latched count
    push_op(OP_FEED, 8'h33, 1'b1, 1'b0);
    push_op(OP_FEED, 8'h44, 1'b1, 1'b0);  // abandons the open block
    push_op(OP_FEED, 8'h55, 1'b0, 1'b0);
    push_op(OP_READ, 8'h00, 1'b1, 1'b0);
    push_op(OP_READ, 8'h00, 1'b1, 1'b0);  // restart while a request is open
    push_op(OP_READ, 8'h00, 1'b0, 1'b1);
    push_op(OP_FEED, 8'h66, 1'b1, 1'b0);
    close_phase();

    // random traffic, mostly small rings so drops and wraps are frequent
    run_phase(0, 3, 2, 85);    // zero block size acts as one
    run_phase(3, 0, 127, 85);  // zero ring blocks acts as one
    run_phase(1, 1, 0, 85);
    run_phase(5, 64, 64, 85);
    for (int p = 0; p < 4; p++)
      run_phase($urandom_range(8, 1), $urandom_range(6, 1), $urandom_range(9), 85);

    // block count product above the ring limit, so the ring size saturates
    set_config(64, 127, 64);
    void'(queue_pair(64, 1, 0, 1, 1));
    void'(queue_pair(64, 1, 32, 1, 1));
    close_phase();

    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
